// ----- hw/rtl/crl_pkg.sv -----
// crl_pkg: shared constants, payload structs and control types of the crank rate lamp bar.
// No dependencies; every rtl file of the block refers to it by scoped names.
package crl_pkg;

	localparam int WINDOW_DEPTH = 5;
	localparam int LAMP_COUNT   = 4;
	localparam int THRESH_REGS  = 4;

	localparam int PERIOD_W   = 22;
	localparam int TIME_W     = 32;
	localparam int RPM_W      = 13;
	localparam int TOL_W      = 13;
	localparam int INTERVAL_W = 16;
	localparam int THR_W      = 13;
	localparam int LAMP_W     = 4;

	localparam int DIV_W     = 26;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);
	localparam int CNT_W     = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_W     = RPM_W + $clog2(WINDOW_DEPTH + 1);

	localparam logic [DIV_W-1:0] RPM_NUMERATOR = DIV_W'(60000000);
	localparam logic [RPM_W-1:0] RPM_MAX       = {RPM_W{1'b1}};

	localparam int REG_COUNT = 7;
	localparam int IDX_W     = $clog2(REG_COUNT);
	localparam int ADDR_W    = IDX_W + 2;
	localparam int DATA_W    = 32;

	localparam logic [IDX_W-1:0] REG_MIN_PERIOD = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_TOLERANCE  = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_INTERVAL   = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_THR0       = IDX_W'(3);
	localparam logic [IDX_W-1:0] REG_THR1       = IDX_W'(4);
	localparam logic [IDX_W-1:0] REG_THR2       = IDX_W'(5);
	localparam logic [IDX_W-1:0] REG_THR3       = IDX_W'(6);

	localparam logic [PERIOD_W-1:0]   RST_MIN_PERIOD = PERIOD_W'(10000);
	localparam logic [TOL_W-1:0]      RST_TOLERANCE  = TOL_W'(100);
	localparam logic [INTERVAL_W-1:0] RST_INTERVAL   = INTERVAL_W'(100);
	localparam logic [THR_W-1:0]      RST_THR0       = THR_W'(50);
	localparam logic [THR_W-1:0]      RST_THR1       = THR_W'(150);
	localparam logic [THR_W-1:0]      RST_THR2       = THR_W'(250);
	localparam logic [THR_W-1:0]      RST_THR3       = THR_W'(400);

	typedef struct packed {
		logic [PERIOD_W-1:0] period_us;
		logic [TIME_W-1:0]   now_ms;
	} in_item_t;

	typedef struct packed {
		logic [LAMP_W-1:0] lamps;
		logic [RPM_W-1:0]  shown_rpm;
		logic              no_signal;
		logic              lamps_updated;
	} out_item_t;

	typedef struct packed {
		logic [PERIOD_W-1:0]                  min_period_us;
		logic [TOL_W-1:0]                     change_tolerance;
		logic [INTERVAL_W-1:0]                update_interval_ms;
		logic [THRESH_REGS-1:0][THR_W-1:0]    lamp_threshold;
	} cfg_t;

	typedef struct packed {
		logic                start;
		logic [DIV_W-1:0]    dividend;
		logic [PERIOD_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic             clear;
		logic             push;
		logic [RPM_W-1:0] rpm;
	} win_cmd_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [CNT_W-1:0] count;
	} win_sts_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RPM,
		ST_AVG_OLD,
		ST_AVG_NEW_GO,
		ST_AVG_NEW,
		ST_DONE
	} seq_state_t;

endpackage

// ----- hw/rtl/crl_regs.sv -----
// crl_regs: APB-style configuration registers with read back.
// Depends on crl_pkg.
module crl_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [crl_pkg::ADDR_W-1:0] paddr,
	input  logic [crl_pkg::DATA_W-1:0] pwdata,
	output logic [crl_pkg::DATA_W-1:0] prdata,
	output crl_pkg::cfg_t             cfg
);

	logic                     wr;
	logic [crl_pkg::IDX_W-1:0] idx;
	crl_pkg::cfg_t            cfg_q;

	assign wr  = psel & penable & pwrite;
	assign idx = paddr[crl_pkg::ADDR_W-1:2];
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_period_us      <= crl_pkg::RST_MIN_PERIOD;
			cfg_q.change_tolerance   <= crl_pkg::RST_TOLERANCE;
			cfg_q.update_interval_ms <= crl_pkg::RST_INTERVAL;
			cfg_q.lamp_threshold[0]  <= crl_pkg::RST_THR0;
			cfg_q.lamp_threshold[1]  <= crl_pkg::RST_THR1;
			cfg_q.lamp_threshold[2]  <= crl_pkg::RST_THR2;
			cfg_q.lamp_threshold[3]  <= crl_pkg::RST_THR3;
		end else if (wr) begin
			unique case (idx)
				crl_pkg::REG_MIN_PERIOD: cfg_q.min_period_us <= pwdata[crl_pkg::PERIOD_W-1:0];
				crl_pkg::REG_TOLERANCE:  cfg_q.change_tolerance <= pwdata[crl_pkg::TOL_W-1:0];
				crl_pkg::REG_INTERVAL: begin
					cfg_q.update_interval_ms <= pwdata[crl_pkg::INTERVAL_W-1:0];
				end
				crl_pkg::REG_THR0: cfg_q.lamp_threshold[0] <= pwdata[crl_pkg::THR_W-1:0];
				crl_pkg::REG_THR1: cfg_q.lamp_threshold[1] <= pwdata[crl_pkg::THR_W-1:0];
				crl_pkg::REG_THR2: cfg_q.lamp_threshold[2] <= pwdata[crl_pkg::THR_W-1:0];
				crl_pkg::REG_THR3: cfg_q.lamp_threshold[3] <= pwdata[crl_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			crl_pkg::REG_MIN_PERIOD: prdata = crl_pkg::DATA_W'(cfg_q.min_period_us);
			crl_pkg::REG_TOLERANCE:  prdata = crl_pkg::DATA_W'(cfg_q.change_tolerance);
			crl_pkg::REG_INTERVAL:   prdata = crl_pkg::DATA_W'(cfg_q.update_interval_ms);
			crl_pkg::REG_THR0:       prdata = crl_pkg::DATA_W'(cfg_q.lamp_threshold[0]);
			crl_pkg::REG_THR1:       prdata = crl_pkg::DATA_W'(cfg_q.lamp_threshold[1]);
			crl_pkg::REG_THR2:       prdata = crl_pkg::DATA_W'(cfg_q.lamp_threshold[2]);
			crl_pkg::REG_THR3:       prdata = crl_pkg::DATA_W'(cfg_q.lamp_threshold[3]);
			default:                 prdata = '0;
		endcase
	end

endmodule

// ----- hw/rtl/crl_divider.sv -----
// crl_divider: shared restoring divider, one quotient bit per cycle.
// Depends on crl_pkg.
module crl_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  crl_pkg::div_req_t req,
	output crl_pkg::div_rsp_t rsp
);

	logic                          busy_q;
	logic                          done_q;
	logic [crl_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [crl_pkg::PERIOD_W-1:0]  rem_q;
	logic [crl_pkg::PERIOD_W-1:0]  dsr_q;
	logic [crl_pkg::DIV_W-1:0]     quo_q;
	logic [crl_pkg::PERIOD_W:0]    shifted;
	logic [crl_pkg::PERIOD_W:0]    trial;
	logic                          fit;
	logic [crl_pkg::PERIOD_W-1:0]  rem_next;

	assign shifted  = {rem_q, quo_q[crl_pkg::DIV_W-1]};
	assign trial    = shifted - {1'b0, dsr_q};
	assign fit      = ~trial[crl_pkg::PERIOD_W];
	assign rem_next = fit ? trial[crl_pkg::PERIOD_W-1:0] : shifted[crl_pkg::PERIOD_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= crl_pkg::DIV_CNT_W'(crl_pkg::DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == crl_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dsr_q <= req.divisor;
			quo_q <= req.dividend;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[crl_pkg::DIV_W-2:0], fit};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ----- hw/rtl/crl_window.sv -----
// crl_window: rpm history window with filled marks, newest at slot 0; gives sum and count.
// Depends on crl_pkg.
module crl_window (
	input  logic              clk,
	input  logic              arst_n,
	input  crl_pkg::win_cmd_t cmd,
	output crl_pkg::win_sts_t sts
);

	logic [crl_pkg::RPM_W-1:0]  rpm_q [crl_pkg::WINDOW_DEPTH];
	logic [crl_pkg::WINDOW_DEPTH-1:0] filled_q;
	logic [crl_pkg::SUM_W-1:0]  sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q <= '0;
		end else if (cmd.push) begin
			for (int i = 1; i < crl_pkg::WINDOW_DEPTH; i++) begin
				filled_q[i] <= cmd.clear ? 1'b0 : filled_q[i-1];
			end
			filled_q[0] <= 1'b1;
		end else if (cmd.clear) begin
			filled_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			for (int i = 1; i < crl_pkg::WINDOW_DEPTH; i++) begin
				rpm_q[i] <= rpm_q[i-1];
			end
			rpm_q[0] <= cmd.rpm;
		end
	end

	always_comb begin
		sum = '0;
		for (int i = 0; i < crl_pkg::WINDOW_DEPTH; i++) begin
			if (filled_q[i]) begin
				sum = sum + crl_pkg::SUM_W'(rpm_q[i]);
			end
		end
	end

	assign sts.sum   = sum;
	assign sts.count = crl_pkg::CNT_W'($countones(filled_q));

endmodule

// ----- hw/rtl/crank_rate_lamp_bar_unit.sv -----
// crank_rate_lamp_bar_unit: top level, sequencer over one shared divider.
// A no-signal request loads the result register directly on accept; otherwise it takes
// one to three divisions (rpm, old average, new average) in turn on the divider.
// A new request is taken only in idle, so not while one is in progress, and not while a
// finished result waits for the output register, which still holds an untaken result.
// Reset restores the register defaults, empties the window and turns all lamps off.
module crank_rate_lamp_bar_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  crl_pkg::in_item_t          in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output crl_pkg::out_item_t         out_data,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [crl_pkg::ADDR_W-1:0] paddr,
	input  logic [crl_pkg::DATA_W-1:0] pwdata,
	output logic [crl_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);

	crl_pkg::cfg_t              cfg;
	crl_pkg::div_req_t          div_req;
	crl_pkg::div_rsp_t          div_rsp;
	crl_pkg::win_cmd_t          win_cmd;
	crl_pkg::win_sts_t          win_sts;
	crl_pkg::seq_state_t        state_q, state_d;

	logic [crl_pkg::TIME_W-1:0]   now_q;
	logic [crl_pkg::RPM_W-1:0]    rpm_q;
	logic [crl_pkg::LAMP_W-1:0]   lamp_bits_q, lamp_d;
	logic [crl_pkg::TIME_W-1:0]   last_ms_q;
	crl_pkg::out_item_t           res_q, res_d, out_q;
	logic                         out_valid_q;

	logic                         accept, no_sig;
	logic                         rpm_load, res_load, lamp_load, last_load, out_load;
	logic [crl_pkg::RPM_W-1:0]    rpm_sat, avg, diff;
	logic [crl_pkg::TIME_W-1:0]   elapsed;

	crl_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.cfg    (cfg)
	);

	crl_divider u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	crl_window u_win (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (win_cmd),
		.sts   (win_sts)
	);

	assign pready   = 1'b1;
	assign in_ready = (state_q == crl_pkg::ST_IDLE);
	assign accept   = in_valid & in_ready;
	assign no_sig   = (in_data.period_us == '0) || (in_data.period_us < cfg.min_period_us);

	assign rpm_sat = (div_rsp.quotient > crl_pkg::DIV_W'(crl_pkg::RPM_MAX)) ?
		crl_pkg::RPM_MAX : div_rsp.quotient[crl_pkg::RPM_W-1:0];
	assign avg     = div_rsp.quotient[crl_pkg::RPM_W-1:0];
	assign diff    = (avg > rpm_q) ? (avg - rpm_q) : (rpm_q - avg);
	assign elapsed = now_q - last_ms_q;

	always_comb begin
		lamp_d = '0;
		for (int i = 0; i < crl_pkg::THRESH_REGS; i++) begin
			lamp_d[i] = (i < crl_pkg::LAMP_COUNT) && (avg >= cfg.lamp_threshold[i]);
		end
	end

	always_comb begin
		state_d          = state_q;
		div_req.start    = 1'b0;
		div_req.dividend = crl_pkg::DIV_W'(win_sts.sum);
		div_req.divisor  = crl_pkg::PERIOD_W'(win_sts.count);
		win_cmd.clear    = 1'b0;
		win_cmd.push     = 1'b0;
		win_cmd.rpm      = rpm_q;
		rpm_load         = 1'b0;
		res_load         = 1'b0;
		res_d            = '{lamps: lamp_bits_q, shown_rpm: rpm_q, no_signal: 1'b0,
			lamps_updated: 1'b0};
		lamp_load        = 1'b0;
		last_load        = 1'b0;
		out_load         = 1'b0;
		unique case (state_q)
			crl_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (no_sig) begin
						win_cmd.clear = 1'b1;
						lamp_load     = 1'b1;
						res_load      = 1'b1;
						res_d         = '{lamps: '0, shown_rpm: '0, no_signal: 1'b1,
							lamps_updated: 1'b0};
						state_d       = crl_pkg::ST_DONE;
					end else begin
						div_req.start    = 1'b1;
						div_req.dividend = crl_pkg::RPM_NUMERATOR;
						div_req.divisor  = in_data.period_us;
						state_d          = crl_pkg::ST_RPM;
					end
				end
			end
			crl_pkg::ST_RPM: begin
				if (div_rsp.done) begin
					rpm_load = 1'b1;
					if (win_sts.count == '0) begin
						win_cmd.push = 1'b1;
						win_cmd.rpm  = rpm_sat;
						res_load     = 1'b1;
						res_d.shown_rpm = rpm_sat;
						state_d      = crl_pkg::ST_DONE;
					end else begin
						div_req.start = 1'b1;
						state_d       = crl_pkg::ST_AVG_OLD;
					end
				end
			end
			crl_pkg::ST_AVG_OLD: begin
				if (div_rsp.done) begin
					win_cmd.push = 1'b1;
					if (diff >= cfg.change_tolerance) begin
						win_cmd.clear = 1'b1;
						res_load      = 1'b1;
						state_d       = crl_pkg::ST_DONE;
					end else if (elapsed >= crl_pkg::TIME_W'(cfg.update_interval_ms)) begin
						state_d = crl_pkg::ST_AVG_NEW_GO;
					end else begin
						res_load = 1'b1;
						state_d  = crl_pkg::ST_DONE;
					end
				end
			end
			crl_pkg::ST_AVG_NEW_GO: begin
				div_req.start = 1'b1;
				state_d       = crl_pkg::ST_AVG_NEW;
			end
			crl_pkg::ST_AVG_NEW: begin
				if (div_rsp.done) begin
					lamp_load = 1'b1;
					last_load = 1'b1;
					res_load  = 1'b1;
					res_d     = '{lamps: lamp_d, shown_rpm: rpm_q, no_signal: 1'b0,
						lamps_updated: 1'b1};
					state_d   = crl_pkg::ST_DONE;
				end
			end
			crl_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = crl_pkg::ST_IDLE;
				end
			end
			default: state_d = crl_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= crl_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			lamp_bits_q <= '0;
			last_ms_q   <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (lamp_load) begin
				lamp_bits_q <= state_q == crl_pkg::ST_IDLE ? '0 : lamp_d;
			end
			if (last_load) begin
				last_ms_q <= now_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			now_q    <= in_data.now_ms;
		end
		if (rpm_load) begin
			rpm_q <= rpm_sat;
		end
		if (res_load) begin
			res_q <= res_d;
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != crl_pkg::ST_IDLE)
		else $error("sequencer stayed idle after a request");

	a_no_signal_dark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.no_signal |-> out_data.lamps == '0 && out_data.shown_rpm == '0)
		else $error("no-signal result carries lamps or rpm");

	a_update_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.no_signal && out_data.lamps_updated))
		else $error("lamp update flagged on a no-signal result");

	a_div_start_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	a_idle_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == crl_pkg::ST_IDLE |-> !div_rsp.busy)
		else $error("divider busy while sequencer idle");

endmodule
